[sv/ech_pkg.sv]
// ---------------------------------------------------------------------------
// ech_pkg
// shared types and constants for the exclusive lfu cache directory
// ---------------------------------------------------------------------------
package ech_pkg;

  localparam int unsigned N_LEVELS = 4;
  localparam int unsigned L0_ENTRIES = 16;
  localparam int unsigned L1_ENTRIES = 32;
  localparam int unsigned L2_ENTRIES = 64;
  localparam int unsigned L3_ENTRIES = 1024;
  localparam int unsigned ADDR_W = 15;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned LVL_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COST_W = 16;
  localparam int unsigned HIT_W = 3;
  localparam int unsigned CLR_CYCLES = L3_ENTRIES;

  localparam logic [TAG_W-1:0] EMPTY_TAG = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_COST_L0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_L1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COST_L2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COST_L3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COST_BK = 3'd4;

  localparam logic [HIT_W-1:0] HIT_BACKING = 3'd4;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN_SEARCH,
    OP_SCAN_VICTIM,
    OP_READ,
    OP_WRITE,
    OP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [LVL_W-1:0]  lvl;
    logic [IDX_W-1:0]  idx;
    logic [TAG_W-1:0]  wr_tag;
    logic [CNT_W-1:0]  wr_cnt;
    logic              wr_bump;
  } dp_cmd_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [IDX_W-1:0]  best_idx;
    logic              best_full;
    logic [TAG_W-1:0]  rd_tag;
    logic [CNT_W-1:0]  rd_cnt;
    logic              done;
  } dp_sts_t;

  function automatic logic [IDX_W-1:0] level_last(logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd0:    r = IDX_W'(L0_ENTRIES - 1);
      2'd1:    r = IDX_W'(L1_ENTRIES - 1);
      2'd2:    r = IDX_W'(L2_ENTRIES - 1);
      default: r = IDX_W'(L3_ENTRIES - 1);
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

[sv/ech_datapath.sv]
// ---------------------------------------------------------------------------
// ech_datapath
// tag and count stores of all levels, with a one entry per cycle scanner
// ---------------------------------------------------------------------------
module ech_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ech_pkg::dp_cmd_t       cmd_i,
  input  logic [ech_pkg::TAG_W-1:0] key_i,
  output ech_pkg::dp_sts_t       sts_o
);
  import ech_pkg::*;

  logic [TAG_W-1:0] tag0 [L0_ENTRIES];
  logic [CNT_W-1:0] cnt0 [L0_ENTRIES];
  logic [TAG_W-1:0] tag1 [L1_ENTRIES];
  logic [CNT_W-1:0] cnt1 [L1_ENTRIES];
  logic [TAG_W-1:0] tag2 [L2_ENTRIES];
  logic [CNT_W-1:0] cnt2 [L2_ENTRIES];
  logic [TAG_W-1:0] tag3 [L3_ENTRIES];
  logic [CNT_W-1:0] cnt3 [L3_ENTRIES];

  // scan pipeline: read address issued, data registered and returned in the next cycle
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             run_q, run_d;
  logic             rvld_q;
  logic [IDX_W-1:0] ridx_q;
  logic             rlast_q;
  logic [TAG_W-1:0] rtag_q;
  logic [CNT_W-1:0] rcnt_q;
  logic             found_q, found_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;
  logic [IDX_W-1:0] bidx_q, bidx_d;
  logic [CNT_W-1:0] bcnt_q, bcnt_d;
  logic             bfull_q, bfull_d;
  logic             done_q, done_d;
  logic             search_q;
  logic [LVL_W-1:0] lvl_q;

  logic [IDX_W-1:0] raddr;
  logic             rd_en;
  logic             start;

  assign start = (cmd_i.op == OP_SCAN_SEARCH) || (cmd_i.op == OP_SCAN_VICTIM);
  assign raddr = (cmd_i.op == OP_READ) ? cmd_i.idx : (start ? '0 : ptr_q);
  assign rd_en = start || run_q || (cmd_i.op == OP_READ);

  // registered reads from the selected level
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      unique case (start || cmd_i.op == OP_READ ? cmd_i.lvl : lvl_q)
        2'd0: begin
          rtag_q <= tag0[raddr[$clog2(L0_ENTRIES)-1:0]];
          rcnt_q <= cnt0[raddr[$clog2(L0_ENTRIES)-1:0]];
        end
        2'd1: begin
          rtag_q <= tag1[raddr[$clog2(L1_ENTRIES)-1:0]];
          rcnt_q <= cnt1[raddr[$clog2(L1_ENTRIES)-1:0]];
        end
        2'd2: begin
          rtag_q <= tag2[raddr[$clog2(L2_ENTRIES)-1:0]];
          rcnt_q <= cnt2[raddr[$clog2(L2_ENTRIES)-1:0]];
        end
        default: begin
          rtag_q <= tag3[raddr];
          rcnt_q <= cnt3[raddr];
        end
      endcase
    end
  end

  // write port: clear of all levels at once, or write with optional saturating bump
  logic [CNT_W-1:0] wcnt;
  logic [TAG_W-1:0] wtag;
  assign wtag = cmd_i.wr_tag;
  assign wcnt = cmd_i.wr_bump ? sat_inc(cmd_i.wr_cnt) : cmd_i.wr_cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      tag0[cmd_i.idx[$clog2(L0_ENTRIES)-1:0]] <= EMPTY_TAG;
      cnt0[cmd_i.idx[$clog2(L0_ENTRIES)-1:0]] <= '0;
      tag1[cmd_i.idx[$clog2(L1_ENTRIES)-1:0]] <= EMPTY_TAG;
      cnt1[cmd_i.idx[$clog2(L1_ENTRIES)-1:0]] <= '0;
      tag2[cmd_i.idx[$clog2(L2_ENTRIES)-1:0]] <= EMPTY_TAG;
      cnt2[cmd_i.idx[$clog2(L2_ENTRIES)-1:0]] <= '0;
      tag3[cmd_i.idx] <= EMPTY_TAG;
      cnt3[cmd_i.idx] <= '0;
    end else if (cmd_i.op == OP_WRITE) begin
      unique case (cmd_i.lvl)
        2'd0: begin
          tag0[cmd_i.idx[$clog2(L0_ENTRIES)-1:0]] <= wtag;
          cnt0[cmd_i.idx[$clog2(L0_ENTRIES)-1:0]] <= wcnt;
        end
        2'd1: begin
          tag1[cmd_i.idx[$clog2(L1_ENTRIES)-1:0]] <= wtag;
          cnt1[cmd_i.idx[$clog2(L1_ENTRIES)-1:0]] <= wcnt;
        end
        2'd2: begin
          tag2[cmd_i.idx[$clog2(L2_ENTRIES)-1:0]] <= wtag;
          cnt2[cmd_i.idx[$clog2(L2_ENTRIES)-1:0]] <= wcnt;
        end
        default: begin
          tag3[cmd_i.idx] <= wtag;
          cnt3[cmd_i.idx] <= wcnt;
        end
      endcase
    end
  end

  // scan control and search / lfu evaluation of the returned entry
  always_comb begin
    ptr_d   = ptr_q;
    run_d   = run_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    bidx_d  = bidx_q;
    bcnt_d  = bcnt_q;
    bfull_d = bfull_q;
    done_d  = 1'b0;
    if (start) begin
      ptr_d   = IDX_W'(1);
      run_d   = (level_last(cmd_i.lvl) != '0);
      found_d = 1'b0;
      bfull_d = 1'b1;
      bidx_d  = '0;
      bcnt_d  = CNT_MAX;
    end else if (run_q) begin
      if (ptr_q == level_last(lvl_q)) begin
        run_d = 1'b0;
      end
      ptr_d = ptr_q + IDX_W'(1);
    end
    if (rvld_q && !done_q && !done_d) begin
      if (search_q) begin
        if (!found_q && rtag_q == key_i) begin
          found_d = 1'b1;
          fidx_d  = ridx_q;
        end
      end else if (bfull_q) begin
        if (rtag_q == EMPTY_TAG) begin
          bfull_d = 1'b0;
          bidx_d  = ridx_q;
        end else if (ridx_q == '0 || rcnt_q < bcnt_q) begin
          bidx_d = ridx_q;
          bcnt_d = rcnt_q;
        end
      end
      if (rlast_q) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      run_q    <= 1'b0;
      rvld_q   <= 1'b0;
      done_q   <= 1'b0;
      search_q <= 1'b0;
      lvl_q    <= '0;
    end else begin
      ptr_q  <= ptr_d;
      run_q  <= run_d;
      rvld_q <= start || run_q;
      done_q <= done_d;
      if (start) begin
        search_q <= (cmd_i.op == OP_SCAN_SEARCH);
        lvl_q    <= cmd_i.lvl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= raddr;
    rlast_q <= (raddr == level_last(start ? cmd_i.lvl : lvl_q));
    found_q <= found_d;
    fidx_q  <= fidx_d;
    bidx_q  <= bidx_d;
    bcnt_q  <= bcnt_d;
    bfull_q <= bfull_d;
  end

  assign sts_o.found     = found_q;
  assign sts_o.found_idx = fidx_q;
  assign sts_o.best_idx  = bidx_q;
  assign sts_o.best_full = bfull_q;
  assign sts_o.rd_tag    = rtag_q;
  assign sts_o.rd_cnt    = rcnt_q;
  assign sts_o.done      = done_q;

endmodule

[sv/ech_ctrl.sv]
// ---------------------------------------------------------------------------
// ech_ctrl
// access sequencer: search levels, pick victims, swap blocks upward
// ---------------------------------------------------------------------------
module ech_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ech_pkg::ADDR_W-1:0] block_address_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [ech_pkg::HIT_W-1:0] res_level_o,
  output ech_pkg::dp_cmd_t          cmd_o,
  output logic [ech_pkg::TAG_W-1:0] key_o,
  input  ech_pkg::dp_sts_t          sts_i
);
  import ech_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;
  localparam logic [3:0] S_SWAIT  = 4'd3;
  localparam logic [3:0] S_RDLO   = 4'd4;
  localparam logic [3:0] S_VIC    = 4'd5;
  localparam logic [3:0] S_VWAIT  = 4'd6;
  localparam logic [3:0] S_RDHI   = 4'd7;
  localparam logic [3:0] S_RHWAIT = 4'd8;
  localparam logic [3:0] S_WRHI   = 4'd9;
  localparam logic [3:0] S_WRLO   = 4'd10;
  localparam logic [3:0] S_FETCH  = 4'd11;
  localparam logic [3:0] S_RLWAIT = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;       // level being searched or lower swap level
  logic [IDX_W-1:0] pos_q, pos_d;       // slot of the block in lvl_q
  logic [IDX_W-1:0] vic_q, vic_d;       // victim slot in level lvl_q-1
  logic [TAG_W-1:0] lo_tag_q, lo_tag_d;
  logic [CNT_W-1:0] lo_cnt_q, lo_cnt_d;
  logic [TAG_W-1:0] hi_tag_q, hi_tag_d;
  logic [CNT_W-1:0] hi_cnt_q, hi_cnt_d;
  logic             bump_hi_q, bump_hi_d;
  logic [HIT_W-1:0] hit_q, hit_d;
  logic [TAG_W-1:0] key_q, key_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             fetch_q, fetch_d;   // victim scan belongs to a backing fetch

  assign key_o       = key_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_level_o = hit_q;

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    pos_d     = pos_q;
    vic_d     = vic_q;
    lo_tag_d  = lo_tag_q;
    lo_cnt_d  = lo_cnt_q;
    hi_tag_d  = hi_tag_q;
    hi_cnt_d  = hi_cnt_q;
    bump_hi_d = bump_hi_q;
    hit_d     = hit_q;
    key_d     = key_q;
    clr_d     = clr_q;
    fetch_d   = fetch_q;
    cmd_o     = '0;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op  = OP_CLEAR;
        cmd_o.idx = clr_q;
        cmd_o.lvl = 2'd0;
        // clear every level in one pass, shorter levels just wrap
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(L3_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          key_d   = TAG_W'(block_address_i);
          lvl_d   = '0;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.op  = OP_SCAN_SEARCH;
        cmd_o.lvl = lvl_q;
        state_d   = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts_i.done) begin
          if (sts_i.found) begin
            pos_d   = sts_i.found_idx;
            hit_d   = HIT_W'(lvl_q);
            state_d = S_RDLO;
          end else if (lvl_q == LVL_W'(N_LEVELS - 1)) begin
            hit_d   = HIT_BACKING;
            fetch_d = 1'b1;
            state_d = S_VIC;
          end else begin
            lvl_d   = lvl_q + LVL_W'(1);
            state_d = S_SRCH;
          end
        end
      end
      // read hit entry (bumped on write back) or fetched victim
      S_RDLO: begin
        cmd_o.op  = OP_READ;
        cmd_o.lvl = lvl_q;
        cmd_o.idx = pos_q;
        state_d   = S_RLWAIT;
      end
      S_RLWAIT: begin
        lo_tag_d = sts_i.rd_tag;
        lo_cnt_d = sts_i.rd_cnt;
        if (hit_q == HIT_W'(lvl_q) && hit_q != HIT_BACKING) begin
          lo_cnt_d = sat_inc(sts_i.rd_cnt);
        end
        if (lvl_q == '0) begin
          // first level hit: write back the bumped count
          state_d = S_WRLO;
        end else begin
          state_d = S_VIC;
        end
      end
      S_VIC: begin
        cmd_o.op  = OP_SCAN_VICTIM;
        cmd_o.lvl = fetch_q ? lvl_q : lvl_q - LVL_W'(1);
        state_d   = S_VWAIT;
      end
      S_VWAIT: begin
        if (sts_i.done) begin
          bump_hi_d = sts_i.best_full;
          if (fetch_q) begin
            pos_d   = sts_i.best_idx;
            state_d = S_FETCH;
          end else begin
            vic_d   = sts_i.best_idx;
            state_d = S_RDHI;
          end
        end
      end
      S_FETCH: begin
        // read victim count then overwrite its tag with the address
        cmd_o.op  = OP_READ;
        cmd_o.lvl = lvl_q;
        cmd_o.idx = pos_q;
        fetch_d   = 1'b0;
        state_d   = S_RLWAIT;
        // tag replaced and full-victim bump folded in on the read-back
      end
      S_RDHI: begin
        cmd_o.op  = OP_READ;
        cmd_o.lvl = lvl_q - LVL_W'(1);
        cmd_o.idx = vic_q;
        state_d   = S_RHWAIT;
      end
      S_RHWAIT: begin
        hi_tag_d = sts_i.rd_tag;
        hi_cnt_d = bump_hi_q ? sat_inc(sts_i.rd_cnt) : sts_i.rd_cnt;
        state_d  = S_WRHI;
      end
      S_WRHI: begin
        // upper slot takes the block
        cmd_o.op      = OP_WRITE;
        cmd_o.lvl     = lvl_q - LVL_W'(1);
        cmd_o.idx     = vic_q;
        cmd_o.wr_tag  = lo_tag_q;
        cmd_o.wr_cnt  = lo_cnt_q;
        cmd_o.wr_bump = 1'b1;
        state_d       = S_WRLO;
      end
      S_WRLO: begin
        cmd_o.op  = OP_WRITE;
        cmd_o.lvl = lvl_q;
        cmd_o.idx = pos_q;
        if (lvl_q == '0) begin
          cmd_o.wr_tag = lo_tag_q;
          cmd_o.wr_cnt = lo_cnt_q;
          state_d      = S_OUT;
        end else begin
          // lower slot takes the displaced entry
          cmd_o.wr_tag  = hi_tag_q;
          cmd_o.wr_cnt  = hi_cnt_q;
          cmd_o.wr_bump = 1'b1;
          // block continues upward from the victim slot
          lo_cnt_d = sat_inc(lo_cnt_q);
          pos_d    = vic_q;
          lvl_d    = lvl_q - LVL_W'(1);
          if (lvl_q == LVL_W'(1)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_VIC;
          end
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // backing fetch: tag becomes the address, full victim count bumped
    if (state_q == S_RLWAIT && hit_q == HIT_BACKING && lvl_q == LVL_W'(N_LEVELS - 1)
        && !fetch_q) begin
      lo_tag_d = key_q;
      lo_cnt_d = bump_hi_q ? sat_inc(sts_i.rd_cnt) : sts_i.rd_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      fetch_q <= 1'b0;
      hit_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fetch_q <= fetch_d;
      hit_q   <= hit_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    vic_q     <= vic_d;
    lo_tag_q  <= lo_tag_d;
    lo_cnt_q  <= lo_cnt_d;
    hi_tag_q  <= hi_tag_d;
    hi_cnt_q  <= hi_cnt_d;
    bump_hi_q <= bump_hi_d;
    key_q     <= key_d;
  end

endmodule

[sv/exclusive_cache_hierarchy_lfu.sv]
// ---------------------------------------------------------------------------
// exclusive_cache_hierarchy_lfu
// tag directory of a four level exclusive hierarchy with lfu replacement
// ---------------------------------------------------------------------------
// usage: an item carries one block address on in_valid_i / in_ready_o. The
// block searches the first, second, third level and main memory in order,
// one entry per cycle, then swaps the block up level by level with an lfu
// victim picked by a further one entry per cycle scan of each upper level.
// One result item (hit_level_o, access_cost_o) leaves on out_valid_o /
// out_ready_i for each input item; one item is worked on at a time.
// A main memory miss scans all 1136 entries to search, 1024 more for the
// main victim and the three upper levels again, through the single read
// port of the directory scanner. Cost registers are written on cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user is to write them only while the block
// is idle, and the block itself does not enforce this.
// Reset: a clearing pass marks every entry empty; no item is accepted until
// it ends. A stalled receiver holds the result in place and the block takes
// no new item until it is delivered.
// ---------------------------------------------------------------------------
module exclusive_cache_hierarchy_lfu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ech_pkg::ADDR_W-1:0]    block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ech_pkg::HIT_W-1:0]     hit_level_o,
  output logic [ech_pkg::COST_W-1:0]    access_cost_o,
  input  logic                          cfg_we_i,
  input  logic [ech_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ech_pkg::COST_W-1:0]    cfg_wdata_i
);
  import ech_pkg::*;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [TAG_W-1:0] key;
  logic [COST_W-1:0] cost_q [5];

  ech_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .block_address_i (block_address_i),
    .res_valid_o     (out_valid_o),
    .res_ready_i     (out_ready_i),
    .res_level_o     (hit_level_o),
    .cmd_o           (cmd),
    .key_o           (key),
    .sts_i           (sts)
  );

  ech_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .key_i  (key),
    .sts_o  (sts)
  );

  // cost registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q[0] <= 16'd10;
      cost_q[1] <= 16'd110;
      cost_q[2] <= 16'd310;
      cost_q[3] <= 16'd1310;
      cost_q[4] <= 16'd12620;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COST_L0: cost_q[0] <= cfg_wdata_i;
        REG_COST_L1: cost_q[1] <= cfg_wdata_i;
        REG_COST_L2: cost_q[2] <= cfg_wdata_i;
        REG_COST_L3: cost_q[3] <= cfg_wdata_i;
        REG_COST_BK: cost_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (hit_level_o)
      3'd0:    access_cost_o = cost_q[0];
      3'd1:    access_cost_o = cost_q[1];
      3'd2:    access_cost_o = cost_q[2];
      3'd3:    access_cost_o = cost_q[3];
      default: access_cost_o = cost_q[4];
    endcase
  end

endmodule
